// ===== rtl/opl_pkg.sv =====
// opl_pkg: shared types and codes for the ordered point list engine
// request and result beat layouts, operation and status codes
// no dependencies
package opl_pkg;

	// operation codes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// request beat
	typedef struct packed {
		logic [2:0]         op;
		logic [5:0]         position;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
	} req_t;

	// result beat
	typedef struct packed {
		logic signed [15:0] read_x;
		logic signed [15:0] read_y;
		logic [6:0]         entry_count;
		logic [1:0]         status;
	} res_t;

endpackage

// ===== rtl/ordered_point_list_engine_top.sv =====
// ordered_point_list_engine_top: ordered list of (x,y) points in one on-chip memory
// single-port-write, registered-read memory plus a shift sequencer
// depends on opl_pkg
//
// Usage
//   Request channel: a beat is taken at a rising edge with start high and busy low.
//   Result channel: one result beat per request, shown for exactly one cycle with
//   done high; the receiver must take it then, there is no back-pressure.
// Result timing
//   append, clear, rejected requests, insert at the end, remove of the last entry:
//   registered at the accepting edge; read: via the memory read and S_READ;
//   other inserts: via S_SHIFT, S_DRAIN, S_PLACE; other removes: S_SHIFT, S_DRAIN.
// Throughput
//   busy is low again in the cycle the result is shown, so a new request may be
//   taken then. Insert and remove move one entry per cycle through the memory
//   (one read and one write each cycle); that shift loop sets the worst-case rate.
// Reset
//   arst_n clears the count and the sequencer; the list is empty afterward.
//   Memory contents are not cleared: only entries below the count are read.
module ordered_point_list_engine_top #(
	parameter int CAPACITY    = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  opl_pkg::req_t req,
	output logic         done,
	output opl_pkg::res_t res
);
	import opl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;
	localparam int SW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_PLACE,
		S_READ
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    ra_q;
	logic [AW-1:0]    stop_q;
	logic [AW-1:0]    pos_q;
	logic [2*SW-1:0]  pt_q;
	logic             ins_q;
	logic             wv_s1;
	logic [AW-1:0]    wa_s1;
	logic             done_q;
	res_t             res_q;

	// point memory with registered read
	logic [2*SW-1:0]  mem [CAPACITY];
	logic [2*SW-1:0]  rd_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [2*SW-1:0]  wdata;
	logic [AW-1:0]    raddr;

	logic             accept;
	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    cnt_w;
	logic             full;
	logic [2*SW-1:0]  new_pt;
	logic             direct_wr;

	assign accept = start && (state_q == S_IDLE);
	assign pos_w  = PW'(req.position);
	assign cnt_w  = PW'(count_q);
	assign full   = (count_q == CW'(CAPACITY));
	assign new_pt = {SW'(req.x_coord), SW'(req.y_coord)};

	// append, or insert exactly at the end, writes straight away
	assign direct_wr = accept && !full &&
		((req.op == OP_APPEND) || ((req.op == OP_INSERT) && (pos_w == cnt_w)));

	// read address: requested position when idle, shift cursor otherwise
	assign raddr = (state_q == S_IDLE) ? AW'(req.position) : ra_q;

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = wa_s1;
		wdata = rd_q;
		priority if (direct_wr) begin
			we    = 1'b1;
			waddr = AW'(count_q);
			wdata = new_pt;
		end else if (wv_s1) begin
			we    = 1'b1;
			waddr = wa_s1;
			wdata = rd_q;
		end else if (state_q == S_PLACE) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = pt_q;
		end
	end

	// memory array
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ra_q    <= '0;
			stop_q  <= '0;
			pos_q   <= '0;
			pt_q    <= '0;
			ins_q   <= 1'b0;
			wv_s1   <= 1'b0;
			wa_s1   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			wv_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q <= AW'(req.position);
						pt_q  <= new_pt;
						res_q <= '0;
						unique case (req.op)
							OP_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									res_q.entry_count <= 7'(count_q);
									res_q.status      <= ST_FULL;
								end else begin
									count_q           <= count_q + 1'b1;
									res_q.entry_count <= 7'(count_q + 1'b1);
									res_q.status      <= ST_DONE;
								end
							end
							OP_INSERT: begin
								if (full) begin
									done_q            <= 1'b1;
									res_q.entry_count <= 7'(count_q);
									res_q.status      <= ST_FULL;
								end else if (pos_w > cnt_w) begin
									done_q            <= 1'b1;
									res_q.entry_count <= 7'(count_q);
									res_q.status      <= ST_RANGE;
								end else if (pos_w == cnt_w) begin
									done_q            <= 1'b1;
									count_q           <= count_q + 1'b1;
									res_q.entry_count <= 7'(count_q + 1'b1);
									res_q.status      <= ST_DONE;
								end else begin
									// move entries up, highest first
									ins_q   <= 1'b1;
									ra_q    <= AW'(count_q - 1'b1);
									stop_q  <= AW'(req.position);
									state_q <= S_SHIFT;
								end
							end
							OP_REMOVE: begin
								if (pos_w >= cnt_w) begin
									done_q            <= 1'b1;
									res_q.entry_count <= 7'(count_q);
									res_q.status      <= ST_RANGE;
								end else if (pos_w == cnt_w - 1'b1) begin
									done_q            <= 1'b1;
									count_q           <= count_q - 1'b1;
									res_q.entry_count <= 7'(count_q - 1'b1);
									res_q.status      <= ST_DONE;
								end else begin
									// move entries down, lowest first
									ins_q   <= 1'b0;
									ra_q    <= AW'(pos_w + 1'b1);
									stop_q  <= AW'(count_q - 1'b1);
									state_q <= S_SHIFT;
								end
							end
							OP_READ: begin
								if (pos_w >= cnt_w) begin
									done_q            <= 1'b1;
									res_q.entry_count <= 7'(count_q);
									res_q.status      <= ST_RANGE;
								end else begin
									state_q <= S_READ;
								end
							end
							OP_CLEAR: begin
								done_q            <= 1'b1;
								count_q           <= '0;
								res_q.entry_count <= '0;
								res_q.status      <= ST_DONE;
							end
							default: begin
								done_q            <= 1'b1;
								res_q.entry_count <= 7'(count_q);
								res_q.status      <= ST_DONE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// one read issued per cycle, written back one slot over next cycle
					wv_s1 <= 1'b1;
					wa_s1 <= ins_q ? ra_q + 1'b1 : ra_q - 1'b1;
					if (ra_q == stop_q)
						state_q <= S_DRAIN;
					else
						ra_q <= ins_q ? ra_q - 1'b1 : ra_q + 1'b1;
				end
				S_DRAIN: begin
					// last moved entry is written this cycle
					if (ins_q) begin
						state_q <= S_PLACE;
					end else begin
						done_q            <= 1'b1;
						count_q           <= count_q - 1'b1;
						res_q.entry_count <= 7'(count_q - 1'b1);
						res_q.status      <= ST_DONE;
						state_q           <= S_IDLE;
					end
				end
				S_PLACE: begin
					done_q            <= 1'b1;
					count_q           <= count_q + 1'b1;
					res_q.entry_count <= 7'(count_q + 1'b1);
					res_q.status      <= ST_DONE;
					state_q           <= S_IDLE;
				end
				S_READ: begin
					done_q            <= 1'b1;
					res_q.read_x      <= 16'(rd_q[2*SW-1:SW]);
					res_q.read_y      <= 16'(rd_q[SW-1:0]);
					res_q.entry_count <= 7'(count_q);
					res_q.status      <= ST_DONE;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// count never goes past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// pending moved-entry writes only happen during a shift
	a_wv_state: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> ((state_q == S_SHIFT) || (state_q == S_DRAIN)))
		else $error("moved-entry write outside shift");

	// a rejected request leaves the count alone
	a_reject_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_q.status != ST_DONE)) |-> $stable(count_q))
		else $error("rejected request changed the count");

	// a shift never reports done while the sequencer is still moving entries
	a_no_done_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |=> !done_q || (state_q == S_SHIFT) || (state_q == S_DRAIN)
			|| ($past(state_q) != S_SHIFT))
		else $error("result during shift");

endmodule

// ===== sim/ordered_point_list_engine_top_test.sv =====
// ordered_point_list_engine_top_test: self-checking bench for the ordered point list engine
// random and directed list requests checked against a shadow list held in the bench
// depends on opl_pkg and ordered_point_list_engine_top
`timescale 1ns / 1ps

module ordered_point_list_engine_top_test;
	import opl_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int DRAIN_CYCLES = 80;

	// op codes the block must ignore
	localparam logic [2:0] OP_RSVD_A = 3'd5;
	localparam logic [2:0] OP_RSVD_B = 3'd6;
	localparam logic [2:0] OP_RSVD_C = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	res_t res;

	ordered_point_list_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	// requests waiting to be sent, and replies owed by the block in order
	req_t request_backlog[$];
	res_t list_replies[$];

	// shadow copy of the point list
	logic signed [15:0] shadow_x[LIST_DEPTH];
	logic signed [15:0] shadow_y[LIST_DEPTH];
	int shadow_count = 0;

	// entry count as tracked while building the stimulus
	int plan_count = 0;

	int fault_count = 0;
	int idle_left = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one request to the shadow list and return the reply it earns
	function automatic res_t apply_to_shadow(req_t r);
		res_t o;
		int i;
		o = '0;
		o.status = ST_DONE;
		case (r.op)
			OP_APPEND: begin
				if (shadow_count >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					shadow_x[shadow_count] = r.x_coord;
					shadow_y[shadow_count] = r.y_coord;
					shadow_count++;
				end
			end
			OP_INSERT: begin
				if (shadow_count >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else if (int'(r.position) > shadow_count) begin
					o.status = ST_RANGE;
				end else begin
					for (i = shadow_count; i > int'(r.position); i--) begin
						shadow_x[i] = shadow_x[i - 1];
						shadow_y[i] = shadow_y[i - 1];
					end
					shadow_x[r.position] = r.x_coord;
					shadow_y[r.position] = r.y_coord;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (int'(r.position) >= shadow_count) begin
					o.status = ST_RANGE;
				end else begin
					for (i = int'(r.position); i + 1 < shadow_count; i++) begin
						shadow_x[i] = shadow_x[i + 1];
						shadow_y[i] = shadow_y[i + 1];
					end
					shadow_count--;
				end
			end
			OP_READ: begin
				if (int'(r.position) >= shadow_count) begin
					o.status = ST_RANGE;
				end else begin
					o.read_x = shadow_x[r.position];
					o.read_y = shadow_y[r.position];
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		o.entry_count = shadow_count[6:0];
		return o;
	endfunction

	// queue a request and follow the count it will leave behind
	task automatic plan_request(input logic [2:0] op, input logic [5:0] pos,
			input logic signed [15:0] x, input logic signed [15:0] y);
		req_t r;
		r.op = op;
		r.position = pos;
		r.x_coord = x;
		r.y_coord = y;
		request_backlog = {request_backlog, r};
		case (op)
			OP_APPEND: if (plan_count < LIST_DEPTH) plan_count++;
			OP_INSERT: if (plan_count < LIST_DEPTH && int'(pos) <= plan_count) plan_count++;
			OP_REMOVE: if (int'(pos) < plan_count) plan_count--;
			OP_CLEAR: plan_count = 0;
			default: ;
		endcase
	endtask

	// coordinate with extra weight on the extremes
	function automatic logic signed [15:0] pick_coord();
		case ($urandom_range(0, 11))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// position mostly inside the list, sometimes anywhere
	function automatic logic [5:0] pick_position(input int limit);
		if (limit < 0 || $urandom_range(0, 6) == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, limit));
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
			fault_count++;
		end
	endtask

	// driver: present backlog beats with random gaps, predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			idle_left = 0;
		end else if (!start || !busy) begin
			if (start) begin
				list_replies = {list_replies, apply_to_shadow(req)};
				if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
				idle_left = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (idle_left == 0 && request_backlog.size() != 0) begin
				start <= 1'b1;
				req <= request_backlog.pop_front();
			end else begin
				start <= 1'b0;
				if (idle_left > 0) idle_left--;
			end
		end
	end

	// monitor: every result beat must match the oldest owed reply
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (list_replies.size() == 0) begin
				$display("%0t: unexpected result beat, expected none got %h", $time, res);
				fault_count++;
			end else begin
				want = list_replies.pop_front();
				compare_field("read_x", want.read_x, res.read_x);
				compare_field("read_y", want.read_y, res.read_y);
				compare_field("entry_count", 16'(want.entry_count), 16'(res.entry_count));
				compare_field("status", 16'(want.status), 16'(res.status));
			end
		end
	end

	// stimulus and end of run
	initial begin
		int seg;
		int n;
		int pick;
		bit filling;
		logic [2:0] op;
		logic [5:0] pos;

		// directed: empty list, extremes, ends and middle, ignored ops, clear
		plan_request(OP_READ, 6'd0, 16'sh0, 16'sh0);
		plan_request(OP_REMOVE, 6'd0, 16'sh0, 16'sh0);
		plan_request(OP_INSERT, 6'd1, 16'sh1111, 16'sh2222);
		plan_request(OP_APPEND, 6'd63, 16'sh7fff, 16'sh8000);
		plan_request(OP_APPEND, 6'd0, 16'sh8000, 16'sh7fff);
		plan_request(OP_APPEND, 6'd0, 16'sh0000, 16'shffff);
		plan_request(OP_INSERT, 6'd0, 16'sh1234, 16'shedcb);
		plan_request(OP_INSERT, 6'd4, 16'shffff, 16'sh0000);
		plan_request(OP_INSERT, 6'd2, 16'sh5555, 16'shaaab);
		plan_request(OP_READ, 6'd0, 16'sh0, 16'sh0);
		plan_request(OP_READ, 6'd5, 16'sh0, 16'sh0);
		plan_request(OP_READ, 6'd6, 16'sh0, 16'sh0);
		plan_request(OP_READ, 6'd63, 16'sh7fff, 16'sh7fff);
		plan_request(OP_REMOVE, 6'd2, 16'sh0, 16'sh0);
		plan_request(OP_REMOVE, 6'd4, 16'sh0, 16'sh0);
		plan_request(OP_REMOVE, 6'd0, 16'sh0, 16'sh0);
		plan_request(OP_RSVD_A, 6'd63, 16'sh7fff, 16'sh8000);
		plan_request(OP_RSVD_B, 6'd0, 16'shffff, 16'shffff);
		plan_request(OP_RSVD_C, 6'd1, 16'sh8000, 16'sh7fff);
		plan_request(OP_READ, 6'd2, 16'sh0, 16'sh0);
		plan_request(OP_CLEAR, 6'd5, 16'sh1, 16'sh1);
		plan_request(OP_READ, 6'd0, 16'sh0, 16'sh0);
		plan_request(OP_APPEND, 6'd0, 16'sh4321, 16'shbcde);
		plan_request(OP_READ, 6'd0, 16'sh0, 16'sh0);

		// random: segments that alternately fill the list up to full and drain it
		for (seg = 0; seg < 8; seg++) begin
			filling = (seg % 2 == 0);
			for (n = 0; n < 200; n++) begin
				pick = $urandom_range(0, 99);
				if (pick == 99) begin
					op = OP_CLEAR;
				end else if (pick >= 97) begin
					op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
				end else if (filling) begin
					op = (pick < 45) ? OP_APPEND : (pick < 70) ? OP_INSERT :
						(pick < 80) ? OP_REMOVE : OP_READ;
				end else begin
					op = (pick < 10) ? OP_APPEND : (pick < 20) ? OP_INSERT :
						(pick < 70) ? OP_REMOVE : OP_READ;
				end
				if (op == OP_INSERT) pos = pick_position(plan_count);
				else pos = pick_position(plan_count - 1);
				plan_request(op, pos, pick_coord(), pick_coord());
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver's updates have settled
		while (request_backlog.size() != 0 || start) @(negedge clk);
		while (list_replies.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d replies still owed", $time, list_replies.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/opl_pkg.sv
rtl/ordered_point_list_engine_top.sv
sim/ordered_point_list_engine_top_test.sv
